// ----- design/dsp_pkg.sv -----
package dsp_pkg;

  // Field widths fixed by the word formats.
  localparam int POS_W   = 32;
  localparam int NPZ_W   = 31;
  localparam int BETA_W  = 32;
  localparam int SLOPE_W = 62;
  localparam int ROOT_W  = 64;
  localparam int ARG_W   = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;

  // Clamps on intermediate magnitudes.
  localparam logic [40:0] DISP_CAP = 41'd1 << 40;
  localparam logic [34:0] PATH_CAP = 35'd1 << 34;

  // Register indexes.
  localparam logic [1:0] REG_DRIFT_LENGTH   = 2'd0;
  localparam logic [1:0] REG_REFERENCE_TIME = 2'd1;

  // Status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] time_coord;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic [30:0]        long_momentum;
    logic [31:0]        velocity_beta;
  } dsp_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_time_coord;
    logic [1:0]         status;
  } dsp_out_t;

  typedef struct packed {
    logic [1:0]  addr;
    logic [31:0] wdata;
  } dsp_cfg_t;

endpackage

// ----- design/dsp_stream_if.sv -----
// Valid/ready channel carrying one word of type T.
interface dsp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dsp_div_cell.sv -----
// One restoring division step: brings down one dividend bit, yields one quotient bit.
module dsp_div_cell #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 31
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [DEN_W-1:0] rem,
  output logic [NUM_W-1:0] num,
  output logic [DEN_W-1:0] den
);
  logic [DEN_W:0] trial;
  logic           ge;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_in, num_in[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_in};

  // Quotient bits enter at the bottom as dividend bits leave at the top.
  always_ff @(posedge clk) begin
    if (en) begin
      rem <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
      num <= {num_in[NUM_W-2:0], ge};
      den <= den_in;
    end
  end
endmodule

// ----- design/dsp_sqrt_cell.sv -----
// One digit-by-digit square root step: two radicand bits in, one root bit out.
module dsp_sqrt_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [dsp_pkg::SQ_REM_W-1:0] rem_in,
  input  logic [dsp_pkg::ROOT_W-1:0]   root_in,
  input  logic [dsp_pkg::ARG_W-1:0]    arg_in,
  output logic [dsp_pkg::SQ_REM_W-1:0] rem,
  output logic [dsp_pkg::ROOT_W-1:0]   root,
  output logic [dsp_pkg::ARG_W-1:0]    arg
);
  import dsp_pkg::*;

  logic [SQ_REM_W+1:0] trial;
  logic [SQ_REM_W+1:0] test;
  logic                ge;

  // Compare the remainder with four times the root plus one.
  assign trial = {rem_in, arg_in[ARG_W-1 -: 2]};
  assign test  = (SQ_REM_W+2)'({root_in, 2'b01});
  assign ge    = trial >= test;

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? SQ_REM_W'(trial - test) : trial[SQ_REM_W-1:0];
      root <= {root_in[ROOT_W-2:0], ge};
      arg  <= {arg_in[ARG_W-3:0], 2'b00};
    end
  end
endmodule

// ----- design/drift_space_particle_push.sv -----
// Channel   Dir  Word        Contents
// particle  in   dsp_in_t    positions, time, momenta, npz, beta
// result    out  dsp_out_t   pushed positions, time, status
// cfg       in   dsp_cfg_t   register index and write data
//
// One particle is accepted every cycle while the skid register is empty; its
// result is offered from the 201st register along the path. The path is made
// up of the chain of cells: 62 slope division cells, 64 square root cells
// and 66 time division cells, plus nine registers for the input, products,
// sums, final time and output.
// Reset is synchronous and empties the pipeline; registers return to L = 1.0.
// A stalled result goes to a skid register; the pipeline holds only once both are full.
module drift_space_particle_push #(
  parameter int FRAC_BITS = 16
) (
  input logic          clk,
  input logic          rst,
  dsp_stream_if.sink   particle,
  dsp_stream_if.source result,
  dsp_stream_if.sink   cfg
);
  import dsp_pkg::*;

  localparam int DIV_N  = SLOPE_W;
  localparam int SQ_N   = ROOT_W;
  localparam int BD_W   = 66;
  localparam int BD_N   = BD_W;
  localparam int N_ST   = 1 + DIV_N + 3 + SQ_N + 3 + BD_N + 1;
  localparam logic [30:0]    DRIFT_RESET = 31'(64'd1 << FRAC_BITS);
  localparam logic [ARG_W-1:0] ARG_ONE   = ARG_W'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] t;
    logic               neg_x;
    logic               neg_y;
    logic               bad;
    logic [31:0]        beta;
  } side1_t;

  typedef struct packed {
    logic [31:0]        new_x;
    logic [31:0]        new_y;
    logic               sat;
    logic signed [31:0] t;
    logic               bad;
    logic [31:0]        beta;
  } side2_t;

  typedef struct packed {
    logic [31:0]        new_x;
    logic [31:0]        new_y;
    logic               sat;
    logic signed [31:0] t;
    logic               bad;
  } side3_t;

  function automatic logic [32:0] sat32(input logic signed [42:0] v);
    logic [32:0] r;
    if (v > 43'sd2147483647) r = {1'b1, 32'h7fffffff};
    else if (v < -43'sd2147483648) r = {1'b1, 32'h80000000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // Configuration registers.
  logic [30:0]        drift_length;
  logic signed [31:0] reference_time;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_length   <= DRIFT_RESET;
      reference_time <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        REG_DRIFT_LENGTH:   drift_length   <= cfg.data.wdata[30:0];
        REG_REFERENCE_TIME: reference_time <= signed'(cfg.data.wdata);
        default: ;
      endcase
    end
  end

  // Pipeline advance and valid chain.
  logic            en;
  logic [N_ST-1:0] vld;
  logic            ov;
  logic            sv;
  dsp_out_t        od;
  dsp_out_t        sd;
  dsp_out_t        fin;

  assign en             = !sv;
  assign particle.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[N_ST-2:0], particle.valid};
  end

  // Input stage: magnitudes of the momenta and the error check.
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [SLOPE_W-1:0] s0_numx;
  logic [SLOPE_W-1:0] s0_numy;
  logic [NPZ_W-1:0]   s0_den;
  side1_t             side1 [DIV_N+1];

  assign ax = particle.data.mom_x[31] ? 32'(-particle.data.mom_x) : particle.data.mom_x;
  assign ay = particle.data.mom_y[31] ? 32'(-particle.data.mom_y) : particle.data.mom_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_numx <= {ax, 30'b0};
      s0_numy <= {ay, 30'b0};
      s0_den  <= particle.data.long_momentum;
      side1[0].pos_x <= particle.data.pos_x;
      side1[0].pos_y <= particle.data.pos_y;
      side1[0].t     <= particle.data.time_coord;
      side1[0].neg_x <= particle.data.mom_x[31];
      side1[0].neg_y <= particle.data.mom_y[31];
      side1[0].bad   <= (particle.data.long_momentum == '0) ||
                        (particle.data.velocity_beta == '0);
      side1[0].beta  <= particle.data.velocity_beta;
      for (int i = 1; i <= DIV_N; i++) side1[i] <= side1[i-1];
    end
  end

  // Slope division lanes.
  logic [NPZ_W-1:0]   xr [DIV_N+1];
  logic [SLOPE_W-1:0] xn [DIV_N+1];
  logic [NPZ_W-1:0]   xd [DIV_N+1];
  logic [NPZ_W-1:0]   yr [DIV_N+1];
  logic [SLOPE_W-1:0] yn [DIV_N+1];
  logic [NPZ_W-1:0]   yd [DIV_N+1];

  assign xr[0] = '0;
  assign xn[0] = s0_numx;
  assign xd[0] = s0_den;
  assign yr[0] = '0;
  assign yn[0] = s0_numy;
  assign yd[0] = s0_den;

  for (genvar g = 0; g < DIV_N; g++) begin : g_slope
    dsp_div_cell #(.NUM_W(SLOPE_W), .DEN_W(NPZ_W)) u_x (
      .clk(clk), .en(en), .rem_in(xr[g]), .num_in(xn[g]), .den_in(xd[g]),
      .rem(xr[g+1]), .num(xn[g+1]), .den(xd[g+1])
    );
    dsp_div_cell #(.NUM_W(SLOPE_W), .DEN_W(NPZ_W)) u_y (
      .clk(clk), .en(en), .rem_in(yr[g]), .num_in(yn[g]), .den_in(yd[g]),
      .rem(yr[g+1]), .num(yn[g+1]), .den(yd[g+1])
    );
  end

  // Partial products of displacements and slope squares.
  logic [SLOPE_W-1:0] sx;
  logic [SLOPE_W-1:0] sy;
  logic [61:0] m1_pxl, m1_pxh, m1_pyl, m1_pyh;
  logic [61:0] m1_xhh, m1_xhl, m1_xll, m1_yhh, m1_yhl, m1_yll;
  side1_t      m1_side;

  assign sx = xn[DIV_N];
  assign sy = yn[DIV_N];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_pxl  <= 62'(drift_length) * 62'(sx[30:0]);
      m1_pxh  <= 62'(drift_length) * 62'(sx[61:31]);
      m1_pyl  <= 62'(drift_length) * 62'(sy[30:0]);
      m1_pyh  <= 62'(drift_length) * 62'(sy[61:31]);
      m1_xhh  <= 62'(sx[61:31]) * 62'(sx[61:31]);
      m1_xhl  <= 62'(sx[61:31]) * 62'(sx[30:0]);
      m1_xll  <= 62'(sx[30:0]) * 62'(sx[30:0]);
      m1_yhh  <= 62'(sy[61:31]) * 62'(sy[61:31]);
      m1_yhl  <= 62'(sy[61:31]) * 62'(sy[30:0]);
      m1_yll  <= 62'(sy[30:0]) * 62'(sy[30:0]);
      m1_side <= side1[DIV_N];
    end
  end

  // Partial product sums.
  logic [92:0]      m2_px;
  logic [92:0]      m2_py;
  logic [ARG_W-1:0] m2_sqx;
  logic [ARG_W-1:0] m2_sqy;
  side1_t           m2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_px   <= 93'(m1_pxl) + (93'(m1_pxh) << 31);
      m2_py   <= 93'(m1_pyl) + (93'(m1_pyh) << 31);
      m2_sqx  <= (ARG_W'(m1_xhh) << 62) + (ARG_W'(m1_xhl) << 32) + ARG_W'(m1_xll);
      m2_sqy  <= (ARG_W'(m1_yhh) << 62) + (ARG_W'(m1_yhl) << 32) + ARG_W'(m1_yll);
      m2_side <= m1_side;
    end
  end

  // New positions and the root argument.
  logic [92:0]        psx;
  logic [92:0]        psy;
  logic [40:0]        dx;
  logic [40:0]        dy;
  logic signed [42:0] sumx;
  logic signed [42:0] sumy;
  logic [32:0]        satx;
  logic [32:0]        saty;
  logic [ARG_W-1:0]   m3_arg;
  side2_t             side2 [SQ_N+1];

  assign psx  = m2_px >> FRAC_BITS;
  assign psy  = m2_py >> FRAC_BITS;
  assign dx   = (psx > 93'(DISP_CAP)) ? DISP_CAP : psx[40:0];
  assign dy   = (psy > 93'(DISP_CAP)) ? DISP_CAP : psy[40:0];
  assign sumx = m2_side.neg_x ? 43'(m2_side.pos_x) - $signed({2'b00, dx})
                              : 43'(m2_side.pos_x) + $signed({2'b00, dx});
  assign sumy = m2_side.neg_y ? 43'(m2_side.pos_y) - $signed({2'b00, dy})
                              : 43'(m2_side.pos_y) + $signed({2'b00, dy});
  assign satx = sat32(sumx);
  assign saty = sat32(sumy);

  always_ff @(posedge clk) begin
    if (en) begin
      m3_arg <= ARG_ONE + m2_sqx + m2_sqy;
      if (m2_side.bad) begin
        side2[0].new_x <= m2_side.pos_x;
        side2[0].new_y <= m2_side.pos_y;
        side2[0].sat   <= 1'b0;
      end else begin
        side2[0].new_x <= satx[31:0];
        side2[0].new_y <= saty[31:0];
        side2[0].sat   <= satx[32] | saty[32];
      end
      side2[0].t    <= m2_side.t;
      side2[0].bad  <= m2_side.bad;
      side2[0].beta <= m2_side.beta;
      for (int i = 1; i <= SQ_N; i++) side2[i] <= side2[i-1];
    end
  end

  // Square root chain.
  logic [SQ_REM_W-1:0] sr [SQ_N+1];
  logic [ROOT_W-1:0]   rt [SQ_N+1];
  logic [ARG_W-1:0]    sa [SQ_N+1];

  assign sr[0] = '0;
  assign rt[0] = '0;
  assign sa[0] = m3_arg;

  for (genvar g = 0; g < SQ_N; g++) begin : g_root
    dsp_sqrt_cell u_sq (
      .clk(clk), .en(en), .rem_in(sr[g]), .root_in(rt[g]), .arg_in(sa[g]),
      .rem(sr[g+1]), .root(rt[g+1]), .arg(sa[g+1])
    );
  end

  // Path length: L times the root, in two partial products.
  logic [62:0]   r1_pl;
  logic [62:0]   r1_ph;
  side2_t        r1_side;
  logic [94:0]   r2_sum;
  side2_t        r2_side;
  logic [94:0]   psd;
  logic [34:0]   dpath;
  logic [BD_W-1:0] r3_num;
  logic [BETA_W-1:0] r3_den;
  side3_t        side3 [BD_N+1];

  assign psd   = r2_sum >> FRAC_BITS;
  assign dpath = (psd > 95'(PATH_CAP)) ? PATH_CAP : psd[34:0];

  always_ff @(posedge clk) begin
    if (en) begin
      r1_pl   <= 63'(drift_length) * 63'(rt[SQ_N][31:0]);
      r1_ph   <= 63'(drift_length) * 63'(rt[SQ_N][63:32]);
      r1_side <= side2[SQ_N];
      r2_sum  <= 95'(r1_pl) + (95'(r1_ph) << 32);
      r2_side <= r1_side;
      r3_num  <= {dpath, 31'b0};
      r3_den  <= r2_side.beta;
      side3[0].new_x <= r2_side.new_x;
      side3[0].new_y <= r2_side.new_y;
      side3[0].sat   <= r2_side.sat;
      side3[0].t     <= r2_side.t;
      side3[0].bad   <= r2_side.bad;
      for (int i = 1; i <= BD_N; i++) side3[i] <= side3[i-1];
    end
  end

  // Time of flight division by beta.
  logic [BETA_W-1:0] br [BD_N+1];
  logic [BD_W-1:0]   bn [BD_N+1];
  logic [BETA_W-1:0] bd [BD_N+1];

  assign br[0] = '0;
  assign bn[0] = r3_num;
  assign bd[0] = r3_den;

  for (genvar g = 0; g < BD_N; g++) begin : g_tof
    dsp_div_cell #(.NUM_W(BD_W), .DEN_W(BETA_W)) u_b (
      .clk(clk), .en(en), .rem_in(br[g]), .num_in(bn[g]), .den_in(bd[g]),
      .rem(br[g+1]), .num(bn[g+1]), .den(bd[g+1])
    );
  end

  // Final time and status.
  logic [40:0]        q;
  logic signed [42:0] tsum;
  logic [32:0]        satt;
  side3_t             ls;

  assign ls   = side3[BD_N];
  assign q    = (bn[BD_N] > BD_W'(DISP_CAP)) ? DISP_CAP : bn[BD_N][40:0];
  assign tsum = 43'(ls.t) + $signed({2'b00, q}) - 43'(reference_time);
  assign satt = sat32(tsum);

  always_ff @(posedge clk) begin
    if (en) begin
      fin.new_pos_x <= ls.new_x;
      fin.new_pos_y <= ls.new_y;
      if (ls.bad) begin
        fin.new_time_coord <= ls.t;
        fin.status         <= ST_BAD;
      end else begin
        fin.new_time_coord <= satt[31:0];
        fin.status         <= (ls.sat | satt[32]) ? ST_SAT : ST_OK;
      end
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (result.ready) begin
        od <= sd;
        sv <= 1'b0;
      end
    end else if (ov && !result.ready) begin
      if (vld[N_ST-1]) begin
        sd <= fin;
        sv <= 1'b1;
      end
    end else begin
      ov <= vld[N_ST-1];
      od <= fin;
    end
  end

  assign result.valid = ov;
  assign result.data  = od;
endmodule
